/* rtl/mcr_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the midpoint circle rasterizer
// no dependencies

package mcr_pkg;

  localparam int COORD_W = 12;
  localparam int RAD_W   = COORD_W - 1;
  localparam int PIX_W   = COORD_W + 1;
  localparam int DEC_W   = COORD_W + 2;
  localparam int DIM_W   = 12;
  localparam int CMP_W   = (PIX_W > DIM_W) ? PIX_W : DIM_W + 1;

  localparam int NUM_PIX = 8;
  localparam int IDX_W   = $clog2(NUM_PIX);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PIX - 1);

  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(600);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(600);

  // one midpoint step: octant point, center and flags
  typedef struct packed {
    logic [RAD_W-1:0]   x;
    logic [RAD_W-1:0]   y;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic               live;
    logic               done;
  } step_t;

endpackage

/* rtl/midpoint_circle_rasterizer.sv */
`timescale 1ns / 1ps
// midpoint circle rasterizer: one midpoint step per item, eight pixels per step
// depends on mcr_pkg
// an accepted item goes from the step buffer through the emitter to the output register
// throughput: one pixel per cycle from the output register while out_ready_i is high;
//   a new item is taken while the previous one is still being emitted
// reset: image size 600 x 600, no circle active, step state cleared to zero

module midpoint_circle_rasterizer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // item input
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 op_i,
  input  logic signed [mcr_pkg::COORD_W-1:0]   center_x_i,
  input  logic signed [mcr_pkg::COORD_W-1:0]   center_y_i,
  input  logic        [mcr_pkg::RAD_W-1:0]     radius_i,
  // pixel output
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [mcr_pkg::PIX_W-1:0]     pixel_x_o,
  output logic signed [mcr_pkg::PIX_W-1:0]     pixel_y_o,
  output logic                                 visible_o,
  output logic                                 last_of_step_o,
  output logic                                 circle_done_o,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [mcr_pkg::PADDR_W-1:0]   paddr,
  input  logic        [mcr_pkg::DATA_W-1:0]    pwdata,
  output logic        [mcr_pkg::DATA_W-1:0]    prdata,
  output logic                                 pready
);

  localparam int COORD_W = mcr_pkg::COORD_W;
  localparam int RAD_W   = mcr_pkg::RAD_W;
  localparam int PIX_W   = mcr_pkg::PIX_W;
  localparam int DEC_W   = mcr_pkg::DEC_W;
  localparam int DIM_W   = mcr_pkg::DIM_W;
  localparam int CMP_W   = mcr_pkg::CMP_W;
  localparam int IDX_W   = mcr_pkg::IDX_W;

  // configuration registers
  logic [DIM_W-1:0] width_q, height_q;
  logic             cfg_wr;

  // circle state
  logic [DEC_W-1:0]   dec_q, dec_d;
  logic [RAD_W-1:0]   sx_q, sx_d, sy_q, sy_d;
  logic [COORD_W-1:0] ccol_q, ccol_d, crow_q, crow_d;
  logic               active_q, active_d;
  logic               live, done;

  // step buffer, emitter and output register
  mcr_pkg::step_t   step_d, step_q, emit_q;
  logic             step_vld_q, emit_vld_q;
  logic [IDX_W-1:0] idx_q;
  logic             in_acc, out_load, emit_free, step_take;

  logic [RAD_W-1:0] a_val, b_val;
  logic [PIX_W-1:0] a_ext, b_ext, cx_ext, cy_ext, px, py;
  logic             vis;

  logic [PIX_W-1:0] pix_x_q, pix_y_q;
  logic             vis_q, last_q, done_q, out_vld_q;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mcr_pkg::WIDTH_RST;
      height_q <= mcr_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        mcr_pkg::REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        mcr_pkg::REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mcr_pkg::REG_WIDTH:  prdata = mcr_pkg::DATA_W'(width_q);
      mcr_pkg::REG_HEIGHT: prdata = mcr_pkg::DATA_W'(height_q);
      default:             prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign out_load  = emit_vld_q && (!out_vld_q || out_ready_i);
  assign emit_free = !emit_vld_q || (out_load && idx_q == mcr_pkg::LAST_IDX);
  assign step_take = step_vld_q && emit_free;
  assign in_ready_o = !step_vld_q || emit_free;
  assign in_acc    = in_valid_i && in_ready_o;

  // ---------------- midpoint step ----------------
  always_comb begin
    dec_d  = dec_q;
    sx_d   = sx_q;
    sy_d   = sy_q;
    ccol_d = ccol_q;
    crow_d = crow_q;
    live   = 1'b0;
    if (op_i == mcr_pkg::OP_START) begin
      ccol_d = center_x_i;
      crow_d = center_y_i;
      sx_d   = '0;
      sy_d   = radius_i;
      dec_d  = DEC_W'(1) - {{(DEC_W-RAD_W){1'b0}}, radius_i};
      live   = 1'b1;
    end else if (active_q) begin
      // negative decision keeps y, otherwise step y down
      if (dec_q[DEC_W-1]) begin
        dec_d = dec_q + {{(DEC_W-RAD_W-1){1'b0}}, sx_q, 1'b0} + DEC_W'(3);
      end else begin
        dec_d = dec_q + {{(DEC_W-RAD_W-1){1'b0}}, sx_q, 1'b0}
                      - {{(DEC_W-RAD_W-1){1'b0}}, sy_q, 1'b0} + DEC_W'(5);
        sy_d  = sy_q - RAD_W'(1);
      end
      sx_d = sx_q + RAD_W'(1);
      live = 1'b1;
    end
    done     = !live || !(sy_d > sx_d);
    active_d = live ? !done : active_q;
  end

  assign step_d = '{x: sx_d, y: sy_d, cx: ccol_d, cy: crow_d, live: live, done: done};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q    <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
      ccol_q   <= '0;
      crow_q   <= '0;
      active_q <= 1'b0;
    end else if (in_acc) begin
      dec_q    <= dec_d;
      sx_q     <= sx_d;
      sy_q     <= sy_d;
      ccol_q   <= ccol_d;
      crow_q   <= crow_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_vld_q <= 1'b0;
    end else if (in_acc) begin
      step_vld_q <= 1'b1;
    end else if (step_take) begin
      step_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      step_q <= step_d;
    end
  end

  // ---------------- emitter: eight octant pixels ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_vld_q <= 1'b0;
      idx_q      <= '0;
    end else if (step_take) begin
      emit_vld_q <= 1'b1;
      idx_q      <= '0;
    end else if (out_load && idx_q == mcr_pkg::LAST_IDX) begin
      emit_vld_q <= 1'b0;
    end else if (out_load) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_take) begin
      emit_q <= step_q;
    end
  end

  // idx bit 0 swaps x and y, bit 1 negates the row term, bit 2 negates the column term
  always_comb begin
    a_val  = idx_q[0] ? emit_q.y : emit_q.x;
    b_val  = idx_q[0] ? emit_q.x : emit_q.y;
    a_ext  = {{(PIX_W-RAD_W){1'b0}}, a_val};
    b_ext  = {{(PIX_W-RAD_W){1'b0}}, b_val};
    cx_ext = {emit_q.cx[COORD_W-1], emit_q.cx};
    cy_ext = {emit_q.cy[COORD_W-1], emit_q.cy};
    px     = idx_q[2] ? cx_ext - a_ext : cx_ext + a_ext;
    py     = idx_q[1] ? cy_ext - b_ext : cy_ext + b_ext;
    vis    = emit_q.live && !px[PIX_W-1] && !py[PIX_W-1]
             && (CMP_W'(px) < CMP_W'(width_q)) && (CMP_W'(py) < CMP_W'(height_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pix_x_q <= px;
      pix_y_q <= py;
      vis_q   <= vis;
      last_q  <= (idx_q == mcr_pkg::LAST_IDX);
      done_q  <= emit_q.done;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign pixel_x_o      = pix_x_q;
  assign pixel_y_o      = pix_y_q;
  assign visible_o      = vis_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_q;

  // ---------------- assertions ----------------
  a_idx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_vld_q && !out_load |=> $stable(idx_q))
    else $error("pixel index moved without an output load");

  a_start_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && op_i == mcr_pkg::OP_START && radius_i != '0 |=> active_q)
    else $error("start with nonzero radius did not activate the circle");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && live && done |=> !active_q)
    else $error("finished circle left active");

  a_visible_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && visible_o |-> !pixel_x_o[PIX_W-1] && !pixel_y_o[PIX_W-1])
    else $error("visible pixel with negative coordinate");

endmodule
